// File: src/rqpr_pkg.sv
`default_nettype none
package rqpr_pkg;

	localparam int DEPTH    = 16;
	localparam int PID_BITS = 16;
	localparam int PID_W    = 16;
	localparam int LOC_W    = 5;
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CMP_W    = (CNT_W > LOC_W) ? CNT_W : LOC_W;

	typedef enum logic [1:0] {
		OP_INS = 2'd0,
		OP_DEQ = 2'd1,
		OP_REM = 2'd2,
		OP_NOP = 2'd3
	} rqpr_op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} rqpr_status_t;

	typedef struct packed {
		logic                ins;
		logic                rem;
		logic [IDX_W-1:0]    tail;
		logic [IDX_W-1:0]    rem_idx;
		logic [PID_BITS-1:0] pid;
	} rqpr_ctl_t;

endpackage
`default_nettype wire

// File: src/ready_queue_positional_removal.sv
// Channel   Signals                          Handshake
// request   kind, pid, location              start high and busy low at a rising edge
// result    removed_pid, status, count       done high for one cycle, no back-pressure
//
// One transaction per cycle: busy stays low and a request may follow in the next cycle.
// The result appears on the cycle after acceptance; the row of entry cells updates at the
// same edge, each cell loading the tail or taking its neighbour's value.
// Reset clears the entry count and the result strobe; entry contents are undefined until written.
// The receiver cannot stall: every result is taken in the cycle it is shown.
`default_nettype none
module ready_queue_positional_removal (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 kind,
	input  logic [rqpr_pkg::PID_W-1:0] pid,
	input  logic [rqpr_pkg::LOC_W-1:0] location,
	output logic                       done,
	output logic [rqpr_pkg::PID_W-1:0] removed_pid,
	output logic [1:0]                 status,
	output logic [rqpr_pkg::LOC_W-1:0] count
);
	import rqpr_pkg::*;

	logic                acc;
	rqpr_op_t            op;
	rqpr_ctl_t           ctl;
	rqpr_status_t        st_d;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    cnt_d;
	logic [CMP_W-1:0]    loc_x;
	logic [CMP_W-1:0]    cnt_x;
	logic                done_q;
	logic [PID_W-1:0]    removed_q;
	rqpr_status_t        status_q;
	logic [CNT_W-1:0]    count_q;
	logic [PID_BITS-1:0] val  [DEPTH];
	logic [PID_BITS-1:0] take [DEPTH+1];
	logic [CMP_W-1:0]    loc_m1;

	assign busy  = 1'b0;
	assign acc   = start && !busy;
	assign op    = rqpr_op_t'(kind);
	assign loc_x = CMP_W'(location);
	assign cnt_x = CMP_W'(cnt_q);
	assign loc_m1 = loc_x - CMP_W'(1);

	always_comb begin
		ctl         = '0;
		ctl.pid     = pid[PID_BITS-1:0];
		ctl.tail    = cnt_q[IDX_W-1:0];
		st_d        = ST_OK;
		cnt_d       = cnt_q;
		unique case (op)
			OP_INS: begin
				if (cnt_q == CNT_W'(DEPTH)) begin
					st_d = ST_FULL;
				end else begin
					ctl.ins = acc;
					cnt_d   = cnt_q + CNT_W'(1);
				end
			end
			OP_DEQ: begin
				if (cnt_q == '0) begin
					st_d = ST_EMPTY;
				end else begin
					ctl.rem = acc;
					cnt_d   = cnt_q - CNT_W'(1);
				end
			end
			OP_REM: begin
				if ((loc_x == '0) || (loc_x > cnt_x)) begin
					st_d = ST_RANGE;
				end else begin
					ctl.rem     = acc;
					ctl.rem_idx = loc_m1[IDX_W-1:0];
					cnt_d       = cnt_q - CNT_W'(1);
				end
			end
			OP_NOP: begin
				st_d = ST_OK;
			end
			default: begin
				st_d = ST_OK;
			end
		endcase
	end

	assign take[DEPTH] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [PID_BITS-1:0] nxt;
		if (i == DEPTH - 1) begin : g_last
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = val[i+1];
		end
		rqpr_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.idx      (IDX_W'(i)),
			.nxt      (nxt),
			.take_in  (take[i+1]),
			.val      (val[i]),
			.take_out (take[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= acc;
			if (acc) begin
				cnt_q <= cnt_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			removed_q <= ctl.rem ? PID_W'(take[0]) : '0;
			status_q  <= st_d;
			count_q   <= cnt_d;
		end
	end

	assign done        = done_q;
	assign removed_pid = removed_q;
	assign status      = status_q;
	assign count       = LOC_W'(count_q);

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("result strobe missing after accepted transaction");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result strobe without transaction");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_FULL)) |-> (count_q == CNT_W'(DEPTH)))
		else $error("full status with queue not full");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_EMPTY)) |-> (count_q == '0))
		else $error("empty status with entries held");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("entry count beyond depth");

endmodule
`default_nettype wire

// File: src/rqpr_cell.sv
`default_nettype none
module rqpr_cell (
	input  logic                          clk,
	input  rqpr_pkg::rqpr_ctl_t           ctl,
	input  logic [rqpr_pkg::IDX_W-1:0]    idx,
	input  logic [rqpr_pkg::PID_BITS-1:0] nxt,
	input  logic [rqpr_pkg::PID_BITS-1:0] take_in,
	output logic [rqpr_pkg::PID_BITS-1:0] val,
	output logic [rqpr_pkg::PID_BITS-1:0] take_out
);
	import rqpr_pkg::*;

	logic [PID_BITS-1:0] val_q;

	// load at the tail, or shift up from the neighbour when a removal lies at or before
	always_ff @(posedge clk) begin
		if (ctl.ins && (idx == ctl.tail)) begin
			val_q <= ctl.pid;
		end else if (ctl.rem && (idx >= ctl.rem_idx)) begin
			val_q <= nxt;
		end
	end

	assign val      = val_q;
	assign take_out = take_in | ((ctl.rem && (idx == ctl.rem_idx)) ? val_q : '0);

endmodule
`default_nettype wire

// File: sim/testbench.sv
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rqpr_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PER_PHASE = 175;
	localparam logic [PID_W-1:0] PID_MASK = {PID_W{1'b1}} >> (PID_W - PID_BITS);

	typedef struct packed {
		logic [PID_W-1:0] removed;
		rqpr_status_t     status;
		logic [LOC_W-1:0] count;
	} queue_result_t;

	typedef struct {
		rqpr_op_t         op;
		logic [PID_W-1:0] pid;
		logic [LOC_W-1:0] loc;
		bit               fixed;
		queue_result_t    res;
	} request_row_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [1:0]       kind;
	logic [PID_W-1:0] pid;
	logic [LOC_W-1:0] location;
	logic             done;
	logic [PID_W-1:0] removed_pid;
	logic [1:0]       status;
	logic [LOC_W-1:0] count;

	bit               req_fixed;
	queue_result_t    req_result;

	logic [PID_BITS-1:0] model_pids[$];
	queue_result_t       pending_results[$];
	request_row_t        directed_rows[0:25];

	int unsigned requests_taken;
	int unsigned results_checked;
	int unsigned mismatches;
	int unsigned stall_cycles;
	int unsigned status_seen[4];
	int unsigned peak_fill;

	ready_queue_positional_removal dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.pid         (pid),
		.location    (location),
		.done        (done),
		.removed_pid (removed_pid),
		.status      (status),
		.count       (count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic queue_result_t apply_request(rqpr_op_t op, logic [PID_W-1:0] new_pid,
			logic [LOC_W-1:0] loc);
		queue_result_t r;
		r = '{removed: '0, status: ST_OK, count: '0};
		case (op)
			OP_INS: begin
				if (model_pids.size() >= DEPTH)
					r.status = ST_FULL;
				else
					model_pids.push_back(PID_BITS'(new_pid & PID_MASK));
			end
			OP_DEQ: begin
				if (model_pids.size() == 0)
					r.status = ST_EMPTY;
				else
					r.removed = PID_W'(model_pids.pop_front());
			end
			OP_REM: begin
				if (loc == 0 || loc > model_pids.size()) begin
					r.status = ST_RANGE;
				end else begin
					r.removed = PID_W'(model_pids[loc - 1]);
					model_pids.delete(loc - 1);
				end
			end
			default: ;
		endcase
		r.count = LOC_W'(model_pids.size());
		return r;
	endfunction

	always @(posedge clk) begin
		queue_result_t want;
		queue_result_t got;
		queue_result_t predicted;
		if (arst_n) begin
			if (done) begin
				got = '{removed: removed_pid, status: rqpr_status_t'(status), count: count};
				if (pending_results.size() == 0) begin
					mismatches++;
					$display("%0t: result with none expected: removed_pid %h status %0d count %0d",
						$time, got.removed, got.status, got.count);
				end else begin
					want = pending_results.pop_front();
					results_checked++;
					status_seen[got.status]++;
					if (got.removed !== want.removed || got.status !== want.status ||
							got.count !== want.count) begin
						mismatches++;
						$display("%0t: expected removed_pid %h status %0d count %0d, got %h %0d %0d",
							$time, want.removed, want.status, want.count,
							got.removed, got.status, got.count);
					end
				end
			end
			if (start && !busy) begin
				predicted = apply_request(rqpr_op_t'(kind), pid, location);
				pending_results.push_back(req_fixed ? req_result : predicted);
				requests_taken++;
				if (model_pids.size() > peak_fill)
					peak_fill = model_pids.size();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, stall_cycles);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic send(rqpr_op_t op, logic [PID_W-1:0] new_pid, logic [LOC_W-1:0] loc,
			bit fixed, queue_result_t res);
		int unsigned target;
		target = requests_taken + 1;
		start      <= 1'b1;
		kind       <= op;
		pid        <= new_pid;
		location   <= loc;
		req_fixed  <= fixed;
		req_result <= res;
		do @(negedge clk); while (requests_taken < target);
	endtask

	task automatic hold_off(int unsigned idle_pct);
		while ($urandom_range(0, 99) < idle_pct) begin
			start    <= 1'b0;
			kind     <= 2'($urandom);
			pid      <= PID_W'($urandom);
			location <= LOC_W'($urandom);
			@(negedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
	endtask

	initial begin
		int unsigned idle_pct[3];
		bit          filling;
		int unsigned r;
		rqpr_op_t    op;
		logic [LOC_W-1:0] loc;
		queue_result_t no_result;

		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		kind = '0;
		pid = '0;
		location = '0;
		req_fixed = 1'b0;
		req_result = '0;
		no_result = '0;
		idle_pct = '{0, 71, 30};
		filling = 1'b1;

		directed_rows = '{
			'{OP_DEQ, 16'h0000,  5'd0, 1'b1, '{16'h0000, ST_EMPTY,  5'd0}},
			'{OP_REM, 16'h0000,  5'd1, 1'b1, '{16'h0000, ST_RANGE,  5'd0}},
			'{OP_NOP, 16'hFFFF, 5'd31, 1'b1, '{16'h0000, ST_OK,     5'd0}},
			'{OP_INS, 16'hFFFF,  5'd0, 1'b1, '{16'h0000, ST_OK,     5'd1}},
			'{OP_INS, 16'h0000, 5'd31, 1'b1, '{16'h0000, ST_OK,     5'd2}},
			'{OP_INS, 16'h0001,  5'd0, 1'b1, '{16'h0000, ST_OK,     5'd3}},
			'{OP_INS, 16'h8000,  5'd0, 1'b1, '{16'h0000, ST_OK,     5'd4}},
			'{OP_INS, 16'h5555,  5'd0, 1'b1, '{16'h0000, ST_OK,     5'd5}},
			'{OP_INS, 16'hAAAA,  5'd0, 1'b1, '{16'h0000, ST_OK,     5'd6}},
			'{OP_INS, 16'h1234,  5'd0, 1'b1, '{16'h0000, ST_OK,     5'd7}},
			'{OP_INS, 16'hFEDC,  5'd0, 1'b1, '{16'h0000, ST_OK,     5'd8}},
			'{OP_INS, 16'h00FF,  5'd0, 1'b1, '{16'h0000, ST_OK,     5'd9}},
			'{OP_INS, 16'hFF00,  5'd0, 1'b1, '{16'h0000, ST_OK,    5'd10}},
			'{OP_INS, 16'h0F0F,  5'd0, 1'b1, '{16'h0000, ST_OK,    5'd11}},
			'{OP_INS, 16'hF0F0,  5'd0, 1'b1, '{16'h0000, ST_OK,    5'd12}},
			'{OP_INS, 16'h3C3C,  5'd0, 1'b1, '{16'h0000, ST_OK,    5'd13}},
			'{OP_INS, 16'hC3C3,  5'd0, 1'b1, '{16'h0000, ST_OK,    5'd14}},
			'{OP_INS, 16'h7FFF,  5'd0, 1'b1, '{16'h0000, ST_OK,    5'd15}},
			'{OP_INS, 16'hBEEF,  5'd0, 1'b1, '{16'h0000, ST_OK,    5'd16}},
			'{OP_INS, 16'hDEAD,  5'd0, 1'b1, '{16'h0000, ST_FULL,  5'd16}},
			'{OP_REM, 16'h0000, 5'd17, 1'b1, '{16'h0000, ST_RANGE, 5'd16}},
			'{OP_REM, 16'h0000, 5'd16, 1'b0, '{16'h0000, ST_OK,     5'd0}},
			'{OP_REM, 16'h0000, 5'd31, 1'b1, '{16'h0000, ST_RANGE, 5'd15}},
			'{OP_REM, 16'h0000,  5'd0, 1'b1, '{16'h0000, ST_RANGE, 5'd15}},
			'{OP_REM, 16'h0000,  5'd5, 1'b0, '{16'h0000, ST_OK,     5'd0}},
			'{OP_DEQ, 16'h0000,  5'd0, 1'b1, '{16'hFFFF, ST_OK,    5'd13}}
		};

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send(directed_rows[i].op, directed_rows[i].pid, directed_rows[i].loc,
				directed_rows[i].fixed, directed_rows[i].res);
		drain_results();

		foreach (idle_pct[ph]) begin
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				hold_off(idle_pct[ph]);
				if (model_pids.size() >= DEPTH)
					filling = 1'b0;
				else if (model_pids.size() == 0)
					filling = 1'b1;
				else if ($urandom_range(0, 99) < 3)
					filling = !filling;
				r = $urandom_range(0, 99);
				if (filling)
					op = (r < 60) ? OP_INS : (r < 75) ? OP_DEQ : (r < 95) ? OP_REM : OP_NOP;
				else
					op = (r < 20) ? OP_INS : (r < 50) ? OP_DEQ : (r < 93) ? OP_REM : OP_NOP;
				if ($urandom_range(0, 99) < 80 && model_pids.size() > 0)
					loc = LOC_W'($urandom_range(1, model_pids.size()));
				else
					loc = LOC_W'($urandom_range(0, 31));
				send(op, PID_W'($urandom_range(0, 65535)), loc, 1'b0, no_result);
			end
			drain_results();
		end

		repeat (4) @(negedge clk);

		$display("%0d requests sent, %0d results checked, peak occupancy %0d",
			requests_taken, results_checked, peak_fill);
		$display("status seen: ok %0d, empty %0d, out of range %0d, full %0d",
			status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_RANGE],
			status_seen[ST_FULL]);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
`default_nettype wire
